@@ design/heu_pkg.sv @@
// heu_pkg: shared types, byte codes and prefix tables of the HTML entity unescaper.
// No dependencies; imported by every module of the block.
package heu_pkg;

    localparam int JOB_DEPTH = 4;  // default depth of the job queue

    localparam logic [7:0] CH_AMP  = 8'h26;  // '&'
    localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
    localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT   = 8'h3E;  // '>'
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_T    = 8'h74;

    // match progress, one state per held prefix
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b0_0000_0001,
        ST_AMP   = 9'b0_0000_0010,  // "&"
        ST_A     = 9'b0_0000_0100,  // "&a"
        ST_AM    = 9'b0_0000_1000,  // "&am"
        ST_AMP_P = 9'b0_0001_0000,  // "&amp"
        ST_G     = 9'b0_0010_0000,  // "&g"
        ST_GT    = 9'b0_0100_0000,  // "&gt"
        ST_L     = 9'b0_1000_0000,  // "&l"
        ST_LT    = 9'b1_0000_0000   // "&lt"
    } t_prog;

    // one unit of back-end work: flush a prefix, then maybe one more byte
    typedef struct packed {
        t_prog      prefix;     // prefix to replay, ST_IDLE for none
        logic       has_extra;  // one byte follows the prefix
        logic [7:0] extra;
        logic       last;       // work closes the stream
    } t_job;

    function automatic logic [2:0] prefix_len(input t_prog p);
        logic [2:0] n;
        case (p)
            ST_AMP:                       n = 3'd1;
            ST_A, ST_G, ST_L:             n = 3'd2;
            ST_AM, ST_GT, ST_LT:          n = 3'd3;
            ST_AMP_P:                     n = 3'd4;
            default:                      n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] prefix_byte(input t_prog p, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0: b = CH_AMP;
            2'd1: begin
                if (p inside {ST_A, ST_AM, ST_AMP_P}) b = CH_A;
                else if (p inside {ST_G, ST_GT})      b = CH_G;
                else                                  b = CH_L;
            end
            2'd2: b = (p inside {ST_AM, ST_AMP_P}) ? CH_M : CH_T;
            default: b = CH_P;
        endcase
        return b;
    endfunction

endpackage

@@ design/html_entity_unescape_core.sv @@
// html_entity_unescape_core: streaming decoder of &amp; &gt; &lt; into & > <.
// Depends on heu_pkg, heu_front, heu_job_fifo, heu_back.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  input    | push / full      | i_in_byte[7:0], i_in_last
//  result   | empty / pop      | o_out_byte[7:0], o_run_last, o_stream_last
//
// Cycles: the front takes one word per cycle while the job queue has room.
// The back emits one result word per cycle while the output register is free or
// popped; a byte yields 1 word for plain text, up to 5 for a broken "&amp", none
// while a match grows. Words pass the job queue, then the output register.
// Reset (synchronous, active low) empties queue and output register; matcher idles.
// full follows the job queue only; a stalled pop fills the queue, then stalls push.
module html_entity_unescape_core
    import heu_pkg::*;
#(
    parameter int JOB_QUEUE_DEPTH = JOB_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_stream_last
);

    // front to queue
    t_job f_job;
    logic f_push;
    logic q_full;
    // queue to back
    t_job q_job;
    logic q_valid;
    logic q_pop;

    // matcher: tracks the partial entity and turns each word into at most one job
    heu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_job_push (f_push),
        .o_job      (f_job)
    );

    // decouples the matcher from multi-word flushes
    heu_job_fifo #(
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    // replays prefix bytes and the trailing byte through the output register
    heu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_job_pop     (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_last (o_stream_last)
    );

    a_stream_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stream_last) |-> o_run_last)
        else $error("stream end not at end of run");

endmodule

@@ design/heu_front.sv @@
// heu_front: match tracker; classifies each input byte into at most one back-end job.
// Depends on heu_pkg.
module heu_front
    import heu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_q_full,
    output logic       o_full,
    output logic       o_job_push,
    output t_job       o_job
);

    t_prog r_state;
    t_prog n_state;
    t_job  job;
    logic  brk;
    logic  accept;

    always_comb begin
        n_state       = ST_IDLE;
        brk           = 1'b0;
        job.prefix    = ST_IDLE;
        job.has_extra = 1'b0;
        job.extra     = i_in_byte;
        job.last      = i_in_last;
        unique case (r_state)
            ST_AMP: begin
                if (i_in_byte == CH_A)      n_state = ST_A;
                else if (i_in_byte == CH_G) n_state = ST_G;
                else if (i_in_byte == CH_L) n_state = ST_L;
                else                        brk = 1'b1;
            end
            ST_A:  if (i_in_byte == CH_M) n_state = ST_AM; else brk = 1'b1;
            ST_AM: if (i_in_byte == CH_P) n_state = ST_AMP_P; else brk = 1'b1;
            ST_G:  if (i_in_byte == CH_T) n_state = ST_GT; else brk = 1'b1;
            ST_L:  if (i_in_byte == CH_T) n_state = ST_LT; else brk = 1'b1;
            ST_AMP_P, ST_GT, ST_LT: begin
                if (i_in_byte == CH_SEMI) begin
                    job.has_extra = 1'b1;
                    job.extra     = (r_state == ST_AMP_P) ? CH_AMP :
                                    (r_state == ST_GT) ? CH_GT : CH_LT;
                end else begin
                    brk = 1'b1;
                end
            end
            default: begin  // idle
                if (i_in_byte == CH_AMP) n_state = ST_AMP;
                else                     job.has_extra = 1'b1;
            end
        endcase
        if (brk) begin
            job.prefix = r_state;
            if (i_in_byte == CH_AMP) n_state = ST_AMP;
            else                     job.has_extra = 1'b1;
        end
        // last byte with a match still open: the held prefix plus this byte
        if (i_in_last && n_state != ST_IDLE) begin
            job.prefix    = r_state;
            job.has_extra = 1'b1;
            job.extra     = i_in_byte;
            n_state       = ST_IDLE;
        end
    end

    assign o_full     = i_q_full;
    assign accept     = i_push && !i_q_full;
    assign o_job      = job;
    assign o_job_push = accept && (job.has_extra || job.prefix != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |=> (r_state == ST_IDLE))
        else $error("match held past last byte");

    a_last_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_last) |-> o_job_push)
        else $error("last byte produced no job");

endmodule

@@ design/heu_job_fifo.sv @@
// heu_job_fifo: short queue of jobs between the front and back ends.
// Depends on heu_pkg.
module heu_job_fifo
    import heu_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into full queue");

endmodule

@@ design/heu_back.sv @@
// heu_back: replays one job a byte per cycle into the output register, while it is free or popped.
// Depends on heu_pkg.
module heu_back
    import heu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_stream_last
);

    logic [2:0] r_idx;
    logic [2:0] plen;
    logic [2:0] jlen;
    logic       emit;
    logic       fin;
    logic [7:0] cur;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_orun;
    logic       r_ostream;

    assign plen = prefix_len(i_job.prefix);
    assign jlen = plen + {2'b00, i_job.has_extra};
    assign emit = i_job_valid && (!r_ovalid || i_pop);
    assign fin  = (r_idx == jlen - 3'd1);
    assign cur  = (r_idx < plen) ? prefix_byte(i_job.prefix, r_idx[1:0]) : i_job.extra;

    assign o_job_pop     = emit && fin;
    assign o_empty       = !r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_run_last    = r_orun;
    assign o_stream_last = r_ostream;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte   <= cur;
            r_orun    <= fin;
            r_ostream <= fin && i_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_idx    <= fin ? 3'd0 : r_idx + 3'd1;
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (r_idx < jlen))
        else $error("replay index past job length");

    a_mid_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> i_job_valid)
        else $error("job left queue mid replay");

endmodule

@@ tb/html_entity_unescape_core_test.sv @@
// html_entity_unescape_core_test: self-checking testbench of the &amp;/&gt;/&lt; decoder.
// Depends on heu_pkg and html_entity_unescape_core; a local decoder model predicts
// every result word, checked in order under several sender and receiver idle mixes.
module html_entity_unescape_core_test;
    import heu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
    localparam int TAIL_CYCLES = 24;      // job queue + output register, with margin
    localparam int MAX_REPORTS = 10;

    // one decoded word as seen on the result side
    typedef struct packed {
        logic [7:0] text;
        logic       run_last;
        logic       stream_last;
    } t_dec_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_stream_last;

    // decoder model state: held prefix, bytes of the word in progress, words owed
    t_prog      match_state = ST_IDLE;
    logic [7:0] decoded_bytes[$];
    t_dec_word  pending_words[$];

    int send_idle_pct = 0;   // chance the sender inserts an idle cycle
    int pop_stall_pct = 0;   // chance the receiver holds off pop
    int items_sent = 0;
    int mismatches = 0;
    int cycle_count = 0;

    html_entity_unescape_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_stream_last (o_stream_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // text of the partial entity held in each match state
    function automatic string held_text(input t_prog s);
        case (s)
            ST_AMP:   return "&";
            ST_A:     return "&a";
            ST_AM:    return "&am";
            ST_AMP_P: return "&amp";
            ST_G:     return "&g";
            ST_GT:    return "&gt";
            ST_L:     return "&l";
            ST_LT:    return "&lt";
            default:  return "";
        endcase
    endfunction

    task automatic replay_prefix(input t_prog s);
        string pre;
        int    k;
        pre = held_text(s);
        for (k = 0; k < pre.len(); k++)
            decoded_bytes.push_back(pre[k]);
    endtask

    // Advance the model by one input word and queue the words it owes.
    task automatic predict_decode(input logic [7:0] b, input logic last);
        t_prog     nxt;
        logic      matched;
        t_dec_word w;
        int        k;
        decoded_bytes.delete();
        nxt = ST_IDLE;
        matched = 1'b0;
        case (match_state)
            ST_AMP: begin
                if (b == CH_A)      nxt = ST_A;
                else if (b == CH_G) nxt = ST_G;
                else if (b == CH_L) nxt = ST_L;
                matched = (nxt != ST_IDLE);
            end
            ST_A:  if (b == CH_M) begin nxt = ST_AM; matched = 1'b1; end
            ST_AM: if (b == CH_P) begin nxt = ST_AMP_P; matched = 1'b1; end
            ST_G:  if (b == CH_T) begin nxt = ST_GT; matched = 1'b1; end
            ST_L:  if (b == CH_T) begin nxt = ST_LT; matched = 1'b1; end
            ST_AMP_P: if (b == CH_SEMI) begin
                decoded_bytes.push_back(CH_AMP);
                matched = 1'b1;
            end
            ST_GT: if (b == CH_SEMI) begin
                decoded_bytes.push_back(CH_GT);
                matched = 1'b1;
            end
            ST_LT: if (b == CH_SEMI) begin
                decoded_bytes.push_back(CH_LT);
                matched = 1'b1;
            end
            default: ;
        endcase
        // broken match (or idle): held text goes out as is, then the byte
        // itself is handled as from idle
        if (!matched) begin
            replay_prefix(match_state);
            if (b == CH_AMP) nxt = ST_AMP;
            else decoded_bytes.push_back(b);
        end
        // end of stream flushes whatever is still held
        if (last) begin
            replay_prefix(nxt);
            nxt = ST_IDLE;
        end
        match_state = nxt;
        for (k = 0; k < decoded_bytes.size(); k++) begin
            w.text        = decoded_bytes[k];
            w.run_last    = (k == decoded_bytes.size() - 1);
            w.stream_last = w.run_last && last;
            pending_words.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random pop, in-order compare against the model
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dec_word want;
        if (i_rst_n && pop && !empty) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: byte %02h run %0b stream %0b",
                             o_out_byte, o_run_last, o_stream_last);
            end else begin
                want = pending_words.pop_front();
                if (o_out_byte !== want.text || o_run_last !== want.run_last ||
                    o_stream_last !== want.stream_last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected byte %02h run %0b stream %0b,",
                                  " got byte %02h run %0b stream %0b"},
                                 want.text, want.run_last, want.stream_last,
                                 o_out_byte, o_run_last, o_stream_last);
                end
            end
        end
        pop <= i_rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("html_entity_unescape_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Push one word; push stays high between back-to-back words and is only
    // lowered when an idle gap is taken, so it never toggles within a step.
    task automatic send_word(input logic [7:0] b, input logic last);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        do @(posedge i_clk); while (full);
        predict_decode(b, last);
        items_sent++;
    endtask

    // send a string; close marks its final byte as end of stream
    task automatic send_text(input string s, input logic close);
        int k;
        for (k = 0; k < s.len(); k++)
            send_word(s[k], close && (k == s.len() - 1));
    endtask

    // hold the sender until every owed word has come out
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_words.size() != 0);
    endtask

    // Complete entities, partial entities cut by a random byte, plus noise
    // drawn from the entity alphabet and arbitrary bytes.
    task automatic run_mixed_stream(input int n_items);
        string ent;
        int    target;
        int    pick;
        int    cut;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(9);
            case ($urandom_range(2))
                0:       ent = "&amp;";
                1:       ent = "&gt;";
                default: ent = "&lt;";
            endcase
            if (pick <= 3) begin
                send_text(ent, $urandom_range(3) == 0);
            end else if (pick <= 5) begin
                // partial entity, sometimes closed mid-match, then a random byte
                cut = $urandom_range(ent.len() - 1, 1);
                send_text(ent.substr(0, cut - 1), $urandom_range(7) == 0);
                send_word(8'($urandom_range(255)), $urandom_range(15) == 0);
            end else if (pick <= 8) begin
                send_word(8'($urandom_range(255)), $urandom_range(15) == 0);
            end else begin
                ent = "&ampglt;";
                send_word(ent[$urandom_range(7)], $urandom_range(15) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("&amp;", 1'b0);
        send_text("&gt;", 1'b0);
        send_text("&lt;", 1'b0);
        send_text("&a&", 1'b0);   // ampersand inside a match restarts it
        send_text("gx", 1'b0);    // breaking byte flushes "&g" then passes
        send_text("&amp", 1'b1);  // stream ends while matching
        send_text("&", 1'b1);     // lone ampersand closing the stream
        wait_drained();
    endtask

    task automatic test_plain_stream();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        run_mixed_stream(48);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 80;
        pop_stall_pct = 0;
        run_mixed_stream(48);
    endtask

    // backs up the job queue; a full drain in the middle checks restart
    task automatic test_receiver_stalls();
        send_idle_pct = 0;
        pop_stall_pct = 80;
        run_mixed_stream(24);
        wait_drained();
        run_mixed_stream(24);
    endtask

    task automatic test_both_idle();
        send_idle_pct = 35;
        pop_stall_pct = 35;
        run_mixed_stream(48);
        send_text("&lt;", 1'b1);  // completed entity as the final word
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_plain_stream();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        wait_drained();
        pop_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("html_entity_unescape_core regression: pass");
        end else begin
            $display("html_entity_unescape_core regression: fail");
        end
        $finish;
    end

endmodule
